FILE: design/i2cm_pkg.sv
package i2cm_pkg;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_START    = 3'd1,
    ACT_RESTART  = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_WRITE    = 3'd4,
    ACT_READ     = 3'd5,
    ACT_SEND_ACK = 3'd6,
    ACT_READ_ACK = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    REG_BIT_PHASE  = 2'd0,
    REG_START_HOLD = 2'd1,
    REG_ACK_SETUP  = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] BIT_PHASE_RST  = 8'd1;
  localparam logic [7:0] START_HOLD_RST = 8'd5;
  localparam logic [7:0] ACK_SETUP_RST  = 8'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_data;
    logic       ack_drive;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
  } out_word_t;

  typedef struct packed {
    logic [7:0] bit_phase_ticks;
    logic [7:0] start_hold_ticks;
    logic [7:0] ack_setup_ticks;
  } cfg_t;

  // A phase length of zero counts as a single tick.
  function automatic logic [7:0] load_ticks(input logic [7:0] n);
    load_ticks = (n == 8'd0) ? 8'd1 : n;
  endfunction

endpackage

FILE: design/i2cm_cfg_regs.sv
module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BIT_PHASE:  cfg_nxt.bit_phase_ticks  = pwdata[7:0];
        REG_START_HOLD: cfg_nxt.start_hold_ticks = pwdata[7:0];
        REG_ACK_SETUP:  cfg_nxt.ack_setup_ticks  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BIT_PHASE:  prdata = {{(DATA_W-8){1'b0}}, cfg_r.bit_phase_ticks};
      REG_START_HOLD: prdata = {{(DATA_W-8){1'b0}}, cfg_r.start_hold_ticks};
      REG_ACK_SETUP:  prdata = {{(DATA_W-8){1'b0}}, cfg_r.ack_setup_ticks};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_phase_ticks  <= BIT_PHASE_RST;
      cfg_r.start_hold_ticks <= START_HOLD_RST;
      cfg_r.ack_setup_ticks  <= ACK_SETUP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/i2cm_core.sv
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_word_t  item,
  input  cfg_t      cfg,
  output out_word_t result
);

  act_t       kind_r,  kind_nxt;
  logic [2:0] step_r,  step_nxt;
  logic [2:0] bidx_r,  bidx_nxt;
  logic [7:0] tick_r,  tick_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r,   scl_nxt;
  logic       sda_r,   sda_nxt;
  logic       ack_r,   ack_nxt;
  logic [7:0] rx_r,    rx_nxt;
  logic       finish;
  act_t       act;
  logic [7:0] tb;
  logic [7:0] ts;

  assign act = act_t'(item.action);
  assign tb  = load_ticks(cfg.bit_phase_ticks);
  assign ts  = load_ticks(cfg.start_hold_ticks);

  always_comb begin
    kind_nxt  = kind_r;
    step_nxt  = step_r;
    bidx_nxt  = bidx_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    finish    = 1'b0;

    if (kind_r == ACT_TICK) begin
      if (act != ACT_TICK) begin
        kind_nxt = act;
        step_nxt = 3'd0;
        bidx_nxt = 3'd0;
        unique case (act)
          ACT_START: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; tick_nxt = ts;
          end
          ACT_RESTART: begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; tick_nxt = ts;
          end
          ACT_STOP: begin
            scl_nxt = 1'b0; sda_nxt = 1'b0; tick_nxt = tb;
          end
          ACT_WRITE: begin
            scl_nxt = 1'b0; shift_nxt = item.write_data; tick_nxt = tb;
          end
          ACT_READ: begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; shift_nxt = 8'd0; tick_nxt = tb;
          end
          ACT_SEND_ACK: begin
            scl_nxt   = 1'b0;
            shift_nxt = {7'd0, item.ack_drive};
            tick_nxt  = load_ticks(cfg.ack_setup_ticks);
          end
          default: begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; tick_nxt = tb;
          end
        endcase
      end
    end else if (act == ACT_TICK) begin
      if (tick_r > 8'd1) begin
        tick_nxt = tick_r - 8'd1;
      end else begin
        tick_nxt = 8'd0;
        step_nxt = step_r + 3'd1;
        unique case (kind_r)
          ACT_START: begin
            if (step_nxt == 3'd1) begin
              sda_nxt = 1'b0; tick_nxt = ts;
            end else if (step_nxt == 3'd2) begin
              scl_nxt = 1'b0; tick_nxt = ts;
            end else begin
              finish = 1'b1;
            end
          end
          ACT_RESTART: begin
            if (step_nxt == 3'd1) begin
              scl_nxt = 1'b1; tick_nxt = ts;
            end else if (step_nxt == 3'd2) begin
              sda_nxt = 1'b0; tick_nxt = ts;
            end else begin
              finish = 1'b1;
            end
          end
          ACT_STOP: begin
            if (step_nxt == 3'd1) begin
              scl_nxt = 1'b1; tick_nxt = tb;
            end else if (step_nxt == 3'd2) begin
              sda_nxt = 1'b1; tick_nxt = tb;
            end else begin
              finish = 1'b1;
            end
          end
          ACT_WRITE: begin
            if (step_nxt == 3'd4 && bidx_r == 3'd7) begin
              sda_nxt = 1'b1;
              finish  = 1'b1;
            end else begin
              if (step_nxt == 3'd4) begin
                bidx_nxt = bidx_r + 3'd1;
                step_nxt = 3'd1;
              end
              if (step_nxt == 3'd1) begin
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
              end else if (step_nxt == 3'd2) begin
                scl_nxt = 1'b1;
              end else begin
                scl_nxt = 1'b0;
              end
              tick_nxt = tb;
            end
          end
          ACT_READ: begin
            if (step_nxt == 3'd1) begin
              scl_nxt = 1'b1; tick_nxt = tb;
            end else if (step_nxt == 3'd2) begin
              shift_nxt = {shift_r[6:0], item.sda_in};
              tick_nxt  = tb;
            end else begin
              scl_nxt = 1'b0;
              if (bidx_r == 3'd7) begin
                rx_nxt = shift_r;
                finish = 1'b1;
              end else begin
                bidx_nxt = bidx_r + 3'd1;
                step_nxt = 3'd0;
                sda_nxt  = 1'b1;
                tick_nxt = tb;
              end
            end
          end
          ACT_SEND_ACK: begin
            if (step_nxt == 3'd1) begin
              sda_nxt = ~shift_r[0]; tick_nxt = tb;
            end else if (step_nxt == 3'd2) begin
              scl_nxt = 1'b1; tick_nxt = tb;
            end else if (step_nxt == 3'd3) begin
              scl_nxt = 1'b0; tick_nxt = tb;
            end else begin
              finish = 1'b1;
            end
          end
          ACT_READ_ACK: begin
            if (step_nxt == 3'd1) begin
              scl_nxt = 1'b1; tick_nxt = tb;
            end else if (step_nxt == 3'd2) begin
              ack_nxt = item.sda_in; scl_nxt = 1'b0; tick_nxt = tb;
            end else begin
              finish = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
        if (finish) begin
          kind_nxt = ACT_TICK;
          step_nxt = 3'd0;
          bidx_nxt = 3'd0;
          tick_nxt = 8'd0;
        end
      end
    end
  end

  always_comb begin
    result.scl_level = scl_nxt;
    result.sda_level = sda_nxt;
    result.busy_res  = (kind_nxt != ACT_TICK);
    result.done_res  = finish;
    result.read_data = rx_nxt;
    result.ack_seen  = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= ACT_TICK;
      step_r  <= 3'd0;
      bidx_r  <= 3'd0;
      tick_r  <= 8'd0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rx_r    <= 8'd0;
    end else if (accept) begin
      kind_r  <= kind_nxt;
      step_r  <= step_nxt;
      bidx_r  <= bidx_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
    end
  end

endmodule

FILE: design/i2c_master_bit_engine.sv
// I2C master bit engine. Each input word is either a command (start, repeated
// start, stop, write byte, read byte, send acknowledge, read acknowledge) or
// one tick of time, and each accepted word gives exactly one result word with
// the SCL and SDA drive levels, busy, a one-word done pulse, the last received
// byte and the last sampled acknowledge. Commands that arrive while a sequence
// runs are ignored. The block takes one word per clock cycle: the sequencer
// state is updated in the cycle of acceptance and the result word sits in an
// output register, so a new word is taken whenever that register is empty or
// is being read out in the same cycle. Phase lengths come from three 8-bit
// registers on the APB port at byte addresses 0, 4 and 8; a value of zero
// counts as one tick.
module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  out_word_t result;
  out_word_t out_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  i2cm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/i2c_master_bit_engine_test.sv
`timescale 1ns / 100ps

module i2c_master_bit_engine_test;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  i2c_master_bit_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // Timing registers as the engine should see them.
  logic [7:0] phase_len = BIT_PHASE_RST;
  logic [7:0] hold_len  = START_HOLD_RST;
  logic [7:0] setup_len = ACK_SETUP_RST;

  // Sequencer state of the engine as predicted.
  act_t       eng_kind  = ACT_TICK;
  logic [2:0] eng_step  = '0;
  logic [3:0] eng_bit   = '0;
  logic [7:0] eng_wait  = '0;
  logic [7:0] eng_shift = '0;
  logic       eng_scl   = 1'b1;
  logic       eng_sda   = 1'b1;
  logic       eng_ack   = 1'b0;
  logic [7:0] eng_rx    = '0;

  in_word_t  cmd_backlog[$];
  out_word_t levels_due[$];
  int        words_queued = 0;
  int        words_taken  = 0;
  int        words_seen   = 0;
  int        errors       = 0;
  int        cycle_cnt    = 0;
  bit        in_taken     = 1'b0;
  int        in_gap       = 0;
  int        in_calm      = 0;
  int        out_gap      = 0;
  int        out_calm     = 0;
  int        hold_trig    = 0;
  int        hold_seen    = 0;
  int        hold_left    = 0;

  function automatic logic [7:0] wait_len(input logic [7:0] n);
    return (n == 8'd0) ? 8'd1 : n;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(15) == 0) ? $urandom_range(40, 20) : $urandom_range(3, 1);
  endfunction

  // Ticks a command needs from acceptance to its done word.
  function automatic int seq_ticks(input act_t a);
    int b;
    int s;
    b = int'(wait_len(phase_len));
    s = int'(wait_len(hold_len));
    case (a)
      ACT_START, ACT_RESTART: return 3 * s;
      ACT_WRITE:              return 25 * b;
      ACT_READ:               return 24 * b;
      ACT_SEND_ACK:           return int'(wait_len(setup_len)) + 3 * b;
      default:                return 3 * b;
    endcase
  endfunction

  function automatic void launch_cmd(input in_word_t w);
    eng_kind = act_t'(w.action);
    eng_step = '0;
    eng_bit  = '0;
    case (eng_kind)
      ACT_START: begin
        eng_scl = 1'b1;
        eng_sda = 1'b1;
        eng_wait = wait_len(hold_len);
      end
      ACT_RESTART: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
        eng_wait = wait_len(hold_len);
      end
      ACT_STOP: begin
        eng_scl = 1'b0;
        eng_sda = 1'b0;
        eng_wait = wait_len(phase_len);
      end
      ACT_WRITE: begin
        eng_scl = 1'b0;
        eng_shift = w.write_data;
        eng_wait = wait_len(phase_len);
      end
      ACT_READ: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
        eng_shift = '0;
        eng_wait = wait_len(phase_len);
      end
      ACT_SEND_ACK: begin
        eng_scl = 1'b0;
        eng_shift = {7'd0, w.ack_drive};
        eng_wait = wait_len(setup_len);
      end
      default: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
        eng_wait = wait_len(phase_len);
      end
    endcase
  endfunction

  // Moves on to the next phase; returns 1 when the sequence is complete.
  function automatic bit phase_expired(input logic sda_s);
    eng_step = eng_step + 3'd1;
    case (eng_kind)
      ACT_START: begin
        if (eng_step == 3'd1) begin
          eng_sda = 1'b0;
          eng_wait = wait_len(hold_len);
          return 1'b0;
        end
        if (eng_step == 3'd2) begin
          eng_scl = 1'b0;
          eng_wait = wait_len(hold_len);
          return 1'b0;
        end
        return 1'b1;
      end
      ACT_RESTART: begin
        if (eng_step == 3'd1) begin
          eng_scl = 1'b1;
          eng_wait = wait_len(hold_len);
          return 1'b0;
        end
        if (eng_step == 3'd2) begin
          eng_sda = 1'b0;
          eng_wait = wait_len(hold_len);
          return 1'b0;
        end
        return 1'b1;
      end
      ACT_STOP: begin
        if (eng_step == 3'd1) begin
          eng_scl = 1'b1;
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        if (eng_step == 3'd2) begin
          eng_sda = 1'b1;
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        return 1'b1;
      end
      ACT_WRITE: begin
        if (eng_step == 3'd4) begin
          if (eng_bit >= 4'd7) begin
            eng_sda = 1'b1;
            return 1'b1;
          end
          eng_bit = eng_bit + 4'd1;
          eng_step = 3'd1;
        end
        if (eng_step == 3'd1) begin
          eng_sda = eng_shift[7];
          eng_shift = {eng_shift[6:0], 1'b0};
        end else if (eng_step == 3'd2) begin
          eng_scl = 1'b1;
        end else begin
          eng_scl = 1'b0;
        end
        eng_wait = wait_len(phase_len);
        return 1'b0;
      end
      ACT_READ: begin
        if (eng_step == 3'd1) begin
          eng_scl = 1'b1;
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        if (eng_step == 3'd2) begin
          eng_shift = {eng_shift[6:0], sda_s};
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        eng_scl = 1'b0;
        if (eng_bit >= 4'd7) begin
          eng_rx = eng_shift;
          return 1'b1;
        end
        eng_bit = eng_bit + 4'd1;
        eng_step = 3'd0;
        eng_sda = 1'b1;
        eng_wait = wait_len(phase_len);
        return 1'b0;
      end
      ACT_SEND_ACK: begin
        if (eng_step == 3'd1) begin
          eng_sda = ~eng_shift[0];
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        if (eng_step == 3'd2) begin
          eng_scl = 1'b1;
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        if (eng_step == 3'd3) begin
          eng_scl = 1'b0;
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        return 1'b1;
      end
      ACT_READ_ACK: begin
        if (eng_step == 3'd1) begin
          eng_scl = 1'b1;
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        if (eng_step == 3'd2) begin
          eng_ack = sda_s;
          eng_scl = 1'b0;
          eng_wait = wait_len(phase_len);
          return 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic out_word_t bus_state_after(input in_word_t w);
    out_word_t r;
    bit        fin;
    fin = 1'b0;
    if (eng_kind == ACT_TICK) begin
      if (act_t'(w.action) != ACT_TICK) launch_cmd(w);
    end else if (act_t'(w.action) == ACT_TICK) begin
      if (eng_wait > 8'd1) begin
        eng_wait = eng_wait - 8'd1;
      end else begin
        eng_wait = '0;
        if (phase_expired(w.sda_in)) begin
          fin = 1'b1;
          eng_kind = ACT_TICK;
          eng_step = '0;
          eng_bit = '0;
          eng_wait = '0;
        end
      end
    end
    r.scl_level = eng_scl;
    r.sda_level = eng_sda;
    r.busy_res  = (eng_kind != ACT_TICK);
    r.done_res  = fin;
    r.read_data = eng_rx;
    r.ack_seen  = eng_ack;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("word %0d: %s", words_seen, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, %0h predicted", name, got, want));
  endtask

  always @(posedge clk) begin
    out_word_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      words_taken++;
      levels_due.push_back(bus_state_after(in_data));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        report_mismatch("result word arrived with none outstanding");
      end else begin
        want = levels_due.pop_front();
        check_field("scl_level", 8'(out_data.scl_level), 8'(want.scl_level));
        check_field("sda_level", 8'(out_data.sda_level), 8'(want.sda_level));
        check_field("busy_res", 8'(out_data.busy_res), 8'(want.busy_res));
        check_field("done_res", 8'(out_data.done_res), 8'(want.done_res));
        check_field("read_data", out_data.read_data, want.read_data);
        check_field("ack_seen", 8'(out_data.ack_seen), 8'(want.ack_seen));
      end
      words_seen++;
    end
  end

  always @(negedge clk) begin
    if (in_calm != 0) in_calm--;
    else if ($urandom_range(199) == 0) in_calm = $urandom_range(300, 100);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_calm == 0 && $urandom_range(3) == 0) begin
        in_gap = gap_len() - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= cmd_backlog.pop_front();
      end
    end
  end

  // Long hold-off on the result side, started from the stimulus sequence.
  always @(negedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (out_calm != 0) out_calm--;
    else if ($urandom_range(199) == 0) out_calm = $urandom_range(300, 100);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (out_gap != 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (out_calm == 0 && $urandom_range(3) == 0) begin
      out_gap = gap_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_word(input act_t a, input logic [7:0] d, input logic k, input logic sd);
    in_word_t w;
    w.action = a;
    w.write_data = d;
    w.ack_drive = k;
    w.sda_in = sd;
    cmd_backlog.push_back(w);
    words_queued++;
  endtask

  // A negative sda_fix gives a random line level on every tick.
  task automatic push_ticks(input int n, input int sda_fix);
    for (int i = 0; i < n; i++) begin
      push_word(ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                (sda_fix < 0) ? 1'($urandom_range(1)) : 1'(sda_fix));
    end
  endtask

  task automatic run_cmd(input act_t a, input logic [7:0] d, input logic k, input int sda_fix,
                         input int extra);
    int n;
    n = seq_ticks(a) + extra;
    push_word(a, d, k, 1'($urandom_range(1)));
    push_ticks((n < 0) ? 0 : n, sda_fix);
  endtask

  task automatic drain();
    do @(negedge clk); while (words_taken != words_queued || levels_due.size() != 0);
  endtask

  // Runs the engine back to idle so that the timing registers may be rewritten.
  task automatic settle();
    drain();
    while (eng_kind != ACT_TICK) begin
      @(posedge clk);
      push_ticks(1, -1);
      drain();
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BIT_PHASE:  phase_len = v;
      REG_START_HOLD: hold_len = v;
      REG_ACK_SETUP:  setup_len = v;
      default: begin end
    endcase
  endtask

  task automatic set_timing(input logic [7:0] b, input logic [7:0] s, input logic [7:0] a);
    settle();
    write_reg(REG_BIT_PHASE, b);
    write_reg(REG_START_HOLD, s);
    write_reg(REG_ACK_SETUP, a);
    @(posedge clk);
  endtask

  // Mostly complete sequences, with stray words and sequences cut short mixed in.
  task automatic random_traffic(input int budget);
    int   first;
    int   pick;
    int   n;
    act_t a;
    first = words_queued;
    while (words_queued - first < budget) begin
      pick = $urandom_range(9);
      a = act_t'($urandom_range(7, 1));
      if (pick == 0) begin
        push_word(act_t'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (pick == 1) begin
        n = seq_ticks(a);
        run_cmd(a, 8'($urandom_range(255)), 1'($urandom_range(1)), -1,
                -$urandom_range(n, 1));
      end else begin
        run_cmd(a, 8'($urandom_range(255)), 1'($urandom_range(1)), -1, $urandom_range(2));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: idle tick, a command while busy, and every command at its edges.
    push_ticks(1, -1);
    push_word(ACT_START, 8'h00, 1'b0, 1'b1);
    push_word(ACT_WRITE, 8'hff, 1'b1, 1'b0);
    push_ticks(seq_ticks(ACT_START), -1);
    run_cmd(ACT_RESTART, 8'h00, 1'b0, -1, 0);
    run_cmd(ACT_WRITE, 8'hff, 1'b0, -1, 0);
    run_cmd(ACT_WRITE, 8'h00, 1'b1, -1, 0);
    run_cmd(ACT_READ, 8'h00, 1'b0, 1, 0);
    run_cmd(ACT_READ, 8'hff, 1'b1, 0, 0);
    run_cmd(ACT_SEND_ACK, 8'h00, 1'b1, -1, 0);
    run_cmd(ACT_SEND_ACK, 8'hff, 1'b0, -1, 0);
    run_cmd(ACT_READ_ACK, 8'h00, 1'b0, 1, 0);
    run_cmd(ACT_READ_ACK, 8'h00, 1'b0, 0, 1);
    run_cmd(ACT_STOP, 8'h00, 1'b0, -1, 0);

    // A zero in any timing register counts as a single tick.
    set_timing(8'd0, 8'd0, 8'd0);
    for (int c = int'(ACT_START); c <= int'(ACT_READ_ACK); c++) begin
      run_cmd(act_t'(c), 8'($urandom_range(255)), 1'($urandom_range(1)), -1, 0);
    end

    set_timing(8'd1, 8'd1, 8'd255);
    run_cmd(ACT_SEND_ACK, 8'h00, 1'b1, -1, 0);

    for (int p = 0; p < 4; p++) begin
      set_timing(8'($urandom_range(2, 1)), 8'($urandom_range(4, 1)), 8'($urandom_range(6, 1)));
      if (p == 1) hold_trig++;
      random_traffic(25);
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("i2c_master_bit_engine: match");
    end else begin
      $display("i2c_master_bit_engine: mismatch");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("i2c_master_bit_engine: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
design/i2cm_pkg.sv
design/i2cm_cfg_regs.sv
design/i2cm_core.sv
design/i2c_master_bit_engine.sv
dv/i2c_master_bit_engine_test.sv
